// File: rtl/core/imfd_pkg.sv
// Shared types, constants and helpers for the IMU frame parser / fall detector.
// No dependencies; every other file imports this package.
package imfd_pkg;

    localparam int FRAME_LEN   = 11;              // bytes per frame, checksum last
    localparam int IDX_W       = 4;               // byte counter width
    localparam int PAY_FIRST   = 2;               // first payload byte in the frame
    localparam int PAY_BYTES   = 8;               // four 16-bit words
    localparam int PAY_IDX_W   = $clog2(PAY_BYTES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int CNT_W       = 8;

    typedef logic        [7:0]  t_byte;
    typedef logic signed [15:0] t_word;
    typedef logic [CNT_W-1:0]   t_count;

    localparam t_byte HDR_BYTE   = 8'h55;
    localparam t_byte TYPE_ACCEL = 8'h51;
    localparam t_byte TYPE_GYRO  = 8'h52;
    localparam t_byte TYPE_ANGLE = 8'h53;
    localparam t_byte TYPE_OTHER = 8'h55;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_TICK  = 1'b1;
    localparam logic RK_FRAME = 1'b0;
    localparam logic RK_LOST  = 1'b1;

    localparam logic [2:0] REG_PITCH_LOW  = 3'd0;
    localparam logic [2:0] REG_PITCH_HIGH = 3'd1;
    localparam logic [2:0] REG_ROLL_LOW   = 3'd2;
    localparam logic [2:0] REG_ROLL_HIGH  = 3'd3;
    localparam logic [2:0] REG_MIN_FRAMES = 3'd4;

    localparam t_word  RST_PITCH_LOW  = 16'sh8000;
    localparam t_word  RST_PITCH_HIGH = 16'sh7FFF;
    localparam t_word  RST_ROLL_LOW   = 16'sh8000;
    localparam t_word  RST_ROLL_HIGH  = 16'sh7FFF;
    localparam t_count RST_MIN_FRAMES = 8'd10;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef enum logic {
        EV_FRAME = 1'b0,
        EV_TICK  = 1'b1
    } t_ev_kind;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_BACK  = 3'd1,
        DIR_FWD   = 3'd2,
        DIR_RIGHT = 3'd3,
        DIR_LEFT  = 3'd4
    } t_fall;

    typedef struct packed {
        t_ev_kind kind;
        t_byte    frame_type;
        t_word    w0;
        t_word    w1;
        t_word    w2;
        t_word    w3;
    } t_event;

    typedef struct packed {
        t_word  pitch_low;
        t_word  pitch_high;
        t_word  roll_low;
        t_word  roll_high;
        t_count min_frames;
    } t_cfg;

    function automatic logic is_frame_type(input t_byte b);
        return (b == TYPE_ACCEL) || (b == TYPE_GYRO) ||
               (b == TYPE_ANGLE) || (b == TYPE_OTHER);
    endfunction

endpackage

// File: rtl/core/imfd_if.sv
// Valid/ready channel interfaces for the input items and the results.
// Depends on imfd_pkg.
interface imfd_in_if;
    import imfd_pkg::*;
    logic  valid;
    logic  ready;
    logic  operation;
    t_byte rx_byte;

    modport source (output valid, operation, rx_byte, input ready);
    modport sink   (input valid, operation, rx_byte, output ready);
endinterface

interface imfd_out_if;
    import imfd_pkg::*;
    logic       valid;
    logic       ready;
    logic       result_kind;
    t_byte      frame_type;
    t_word      value_x;
    t_word      value_y;
    t_word      value_z;
    t_word      fourth_word;
    logic [2:0] fall_direction;
    logic       link_lost;

    modport source (output valid, result_kind, frame_type, value_x, value_y, value_z,
                    fourth_word, fall_direction, link_lost, input ready);
    modport sink   (input valid, result_kind, frame_type, value_x, value_y, value_z,
                    fourth_word, fall_direction, link_lost, output ready);
endinterface

// File: rtl/core/imu_frame_parser_fall_detect_top.sv
// IMU serial frame parser with fall detection and link watchdog. One item (a received
// byte or a timer tick) is taken every clock cycle while ready is high; the result for
// an accepted item is written into the two-entry event queue and then passes into the
// result register behind it. Ready drops only while the event queue is full, i.e. when
// results are not being taken. Thresholds are written over the APB port.
// Depends on imfd_pkg, imfd_if, imfd_parser, imfd_queue and imfd_back.
module imu_frame_parser_fall_detect_top
    import imfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    imfd_in_if.sink            in_ch,
    imfd_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_reg;
    logic       w_push;
    t_event     w_push_ev;
    logic       w_full;
    logic       w_q_valid;
    t_event     w_head;
    logic       w_pop;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_reg  = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pitch_low  <= RST_PITCH_LOW;
            r_cfg.pitch_high <= RST_PITCH_HIGH;
            r_cfg.roll_low   <= RST_ROLL_LOW;
            r_cfg.roll_high  <= RST_ROLL_HIGH;
            r_cfg.min_frames <= RST_MIN_FRAMES;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_PITCH_LOW:  r_cfg.pitch_low  <= pwdata[15:0];
                REG_PITCH_HIGH: r_cfg.pitch_high <= pwdata[15:0];
                REG_ROLL_LOW:   r_cfg.roll_low   <= pwdata[15:0];
                REG_ROLL_HIGH:  r_cfg.roll_high  <= pwdata[15:0];
                REG_MIN_FRAMES: r_cfg.min_frames <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_PITCH_LOW:  prdata = {16'd0, r_cfg.pitch_low};
            REG_PITCH_HIGH: prdata = {16'd0, r_cfg.pitch_high};
            REG_ROLL_LOW:   prdata = {16'd0, r_cfg.roll_low};
            REG_ROLL_HIGH:  prdata = {16'd0, r_cfg.roll_high};
            REG_MIN_FRAMES: prdata = {{(PDATA_W-CNT_W){1'b0}}, r_cfg.min_frames};
            default:        prdata = '0;
        endcase
    end

    imfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_ch.valid),
        .i_operation (in_ch.operation),
        .i_rx_byte   (in_ch.rx_byte),
        .i_full      (w_full),
        .o_ready     (in_ch.ready),
        .o_push      (w_push),
        .o_event     (w_push_ev)
    );

    imfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_ev),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    imfd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_ev_valid       (w_q_valid),
        .i_event          (w_head),
        .o_pop            (w_pop),
        .i_out_ready      (out_ch.ready),
        .o_valid          (out_ch.valid),
        .o_result_kind    (out_ch.result_kind),
        .o_frame_type     (out_ch.frame_type),
        .o_value_x        (out_ch.value_x),
        .o_value_y        (out_ch.value_y),
        .o_value_z        (out_ch.value_z),
        .o_fourth_word    (out_ch.fourth_word),
        .o_fall_direction (out_ch.fall_direction),
        .o_link_lost      (out_ch.link_lost)
    );

endmodule

// File: rtl/core/imfd_parser.sv
// Front end: byte-level frame parser; turns good frames and ticks into events.
// Depends on imfd_pkg.
module imfd_parser
    import imfd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  logic   i_operation,
    input  t_byte  i_rx_byte,
    input  logic   i_full,
    output logic   o_ready,
    output logic   o_push,
    output t_event o_event
);

    t_phase               r_phase, n_phase;
    logic [IDX_W-1:0]     r_idx, n_idx;
    t_byte                r_sum, n_sum;
    t_byte                r_type;
    t_byte                r_payload [PAY_BYTES];

    logic                 w_take;
    logic                 w_byte;
    logic                 w_last;
    logic [IDX_W-1:0]     w_pay_off;

    assign o_ready   = !i_full;
    assign w_take    = i_valid && o_ready;
    assign w_byte    = w_take && (i_operation == OP_BYTE);
    assign w_last    = (r_idx == IDX_W'(FRAME_LEN - 1));
    assign w_pay_off = r_idx - IDX_W'(PAY_FIRST);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_sum   = r_sum;
        if (w_byte) begin
            unique case (r_phase)
                PH_TYPE: begin
                    if (is_frame_type(i_rx_byte)) begin
                        n_phase = PH_DATA;
                        n_idx   = IDX_W'(PAY_FIRST);
                        n_sum   = r_sum + i_rx_byte;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_DATA: begin
                    if (w_last) begin
                        n_phase = PH_HUNT;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                        n_sum = r_sum + i_rx_byte;
                    end
                end
                default: begin
                    // hunting, and the unused code
                    if (i_rx_byte == HDR_BYTE) begin
                        n_phase = PH_TYPE;
                        n_idx   = IDX_W'(1);
                        n_sum   = i_rx_byte;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_push             = 1'b0;
        o_event.kind       = EV_TICK;
        o_event.frame_type = r_type;
        o_event.w0         = {r_payload[1], r_payload[0]};
        o_event.w1         = {r_payload[3], r_payload[2]};
        o_event.w2         = {r_payload[5], r_payload[4]};
        o_event.w3         = {r_payload[7], r_payload[6]};
        if (w_take) begin
            if (i_operation == OP_TICK) begin
                o_push = 1'b1;
            end else if (r_phase == PH_DATA && w_last && i_rx_byte == r_sum) begin
                o_push       = 1'b1;
                o_event.kind = EV_FRAME;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_idx   <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_byte && r_phase == PH_TYPE) begin
            r_type <= i_rx_byte;
        end
        if (w_byte && r_phase == PH_DATA && !w_last &&
            r_idx < IDX_W'(PAY_FIRST + PAY_BYTES)) begin
            r_payload[w_pay_off[PAY_IDX_W-1:0]] <= i_rx_byte;
        end
    end

endmodule

// File: rtl/core/imfd_queue.sv
// Short event queue between the parser and the back end.
// Depends on imfd_pkg.
module imfd_queue
    import imfd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_data,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_event o_head
);

    t_event              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QCNT_W-1:0]   r_count;
    logic                w_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// File: rtl/core/imfd_back.sv
// Back end: link watchdog, fall decision and the result register.
// Depends on imfd_pkg.
module imfd_back
    import imfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_ev_valid,
    input  t_event     i_event,
    output logic       o_pop,
    input  logic       i_out_ready,
    output logic       o_valid,
    output logic       o_result_kind,
    output t_byte      o_frame_type,
    output t_word      o_value_x,
    output t_word      o_value_y,
    output t_word      o_value_z,
    output t_word      o_fourth_word,
    output logic [2:0] o_fall_direction,
    output logic       o_link_lost
);

    logic   r_connected;
    t_count r_count;
    t_fall  r_fall;
    logic   r_valid;
    logic   r_kind;
    t_byte  r_type;
    t_word  r_w0, r_w1, r_w2, r_w3;
    t_fall  r_dir_out;
    logic   r_lost;

    logic   w_slot;
    logic   w_do;
    logic   w_emit;
    logic   w_is_frame;
    logic   w_lost;
    t_fall  w_dir;
    t_fall  w_new_fall;

    assign w_slot     = !r_valid || i_out_ready;
    assign w_do       = i_ev_valid && w_slot;
    assign o_pop      = w_do;
    assign w_is_frame = (i_event.kind == EV_FRAME);
    assign w_lost     = r_connected && (r_count < i_cfg.min_frames);
    assign w_emit     = w_is_frame || w_lost;

    // roll out of range overrides the pitch result
    always_comb begin
        w_dir = DIR_NONE;
        if (i_event.w1 < i_cfg.pitch_low) begin
            w_dir = DIR_BACK;
        end else if (i_event.w1 > i_cfg.pitch_high) begin
            w_dir = DIR_FWD;
        end
        if (i_event.w0 < i_cfg.roll_low) begin
            w_dir = DIR_RIGHT;
        end else if (i_event.w0 > i_cfg.roll_high) begin
            w_dir = DIR_LEFT;
        end
    end

    assign w_new_fall = (i_event.frame_type == TYPE_ANGLE) ? w_dir : r_fall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_connected <= 1'b0;
            r_count     <= '0;
            r_fall      <= DIR_NONE;
            r_valid     <= 1'b0;
        end else begin
            if (w_slot) begin
                r_valid <= w_do && w_emit;
            end
            if (w_do) begin
                if (w_is_frame) begin
                    r_connected <= 1'b1;
                    r_fall      <= w_new_fall;
                    if (r_count != '1) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end else if (r_connected) begin
                    r_count <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do && w_emit) begin
            if (w_is_frame) begin
                r_kind    <= RK_FRAME;
                r_type    <= i_event.frame_type;
                r_w0      <= i_event.w0;
                r_w1      <= i_event.w1;
                r_w2      <= i_event.w2;
                r_w3      <= i_event.w3;
                r_dir_out <= w_new_fall;
                r_lost    <= 1'b0;
            end else begin
                r_kind    <= RK_LOST;
                r_type    <= '0;
                r_w0      <= '0;
                r_w1      <= '0;
                r_w2      <= '0;
                r_w3      <= '0;
                r_dir_out <= DIR_NONE;
                r_lost    <= 1'b1;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_result_kind    = r_kind;
    assign o_frame_type     = r_type;
    assign o_value_x        = r_w0;
    assign o_value_y        = r_w1;
    assign o_value_z        = r_w2;
    assign o_fourth_word    = r_w3;
    assign o_fall_direction = r_dir_out;
    assign o_link_lost      = r_lost;

endmodule

// File: rtl/core/imfd_checker.sv
// Port-level checks for the frame parser top level, attached by bind.
// Depends on imfd_pkg and imu_frame_parser_fall_detect_top.
module imfd_checker
    import imfd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_result_kind,
    input t_byte      i_frame_type,
    input t_word      i_value_x,
    input t_word      i_value_y,
    input t_word      i_value_z,
    input t_word      i_fourth_word,
    input logic [2:0] i_fall_direction,
    input logic       i_link_lost
);

    // a held result keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable({i_result_kind, i_frame_type, i_value_x, i_value_y, i_value_z,
                 i_fourth_word, i_fall_direction, i_link_lost}))
        else $error("result changed while stalled");

    a_lost_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_result_kind == RK_LOST |->
        i_link_lost && i_frame_type == '0 && i_value_x == '0 && i_value_y == '0 &&
        i_value_z == '0 && i_fourth_word == '0 && i_fall_direction == DIR_NONE)
        else $error("link lost report carries frame data");

    a_frame_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_result_kind == RK_FRAME |->
        !i_link_lost && i_fall_direction <= DIR_LEFT &&
        (i_frame_type == TYPE_ACCEL || i_frame_type == TYPE_GYRO ||
         i_frame_type == TYPE_ANGLE || i_frame_type == TYPE_OTHER))
        else $error("bad frame result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

endmodule

bind imu_frame_parser_fall_detect_top imfd_checker u_imfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (out_ch.valid),
    .i_out_ready      (out_ch.ready),
    .i_result_kind    (out_ch.result_kind),
    .i_frame_type     (out_ch.frame_type),
    .i_value_x        (out_ch.value_x),
    .i_value_y        (out_ch.value_y),
    .i_value_z        (out_ch.value_z),
    .i_fourth_word    (out_ch.fourth_word),
    .i_fall_direction (out_ch.fall_direction),
    .i_link_lost      (out_ch.link_lost)
);
